FILE: rtl/cvl_pkg.sv
// ----------------------------------------------------------------------------
// cvl_pkg
// Shared types and constants of the compacting value list: sizes, opcodes,
// status codes, the controller states and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package cvl_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CAP_W       = 7;
    localparam int OPCODE_W    = 2;
    localparam int STATUS_W    = 2;
    localparam int FIDX_W      = 6;
    localparam int ECNT_W      = 7;

    // first-match tree: groups of cells encoded in the first level
    localparam int GROUP_SIZE  = 8;
    localparam int SUB_W       = $clog2(GROUP_SIZE);
    localparam int NUM_GROUPS  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GIDX_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int PAD_W       = NUM_GROUPS * GROUP_SIZE;

    localparam int IN_TDATA_W  = ((OPCODE_W + VALUE_W + 7) / 8) * 8;
    localparam int RES_W       = STATUS_W + FIDX_W + ECNT_W + 2;
    localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

    localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_GRP,
        S_RES
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic               append_en;
        logic               delete_en;
        logic [IDX_W-1:0]   pos;
        logic [CNT_W-1:0]   count;
        logic [VALUE_W-1:0] value;
    } cmd_t;

    // result item, status in the lowest bits
    typedef struct packed {
        logic                is_empty;
        logic                is_full;
        logic [ECNT_W-1:0]   entry_count;
        logic [FIDX_W-1:0]   found_index;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

FILE: rtl/cvl_cell.sv
// ----------------------------------------------------------------------------
// cvl_cell
// One list slot: holds a value, compares it against the broadcast value and
// takes the value of its upper neighbor when a delete closes a gap below it.
// ----------------------------------------------------------------------------
module cvl_cell (
    input  logic                        clk,
    input  logic [cvl_pkg::IDX_W-1:0]   idx,
    input  cvl_pkg::cmd_t               cmd,
    input  logic [cvl_pkg::VALUE_W-1:0] next_value,
    output logic [cvl_pkg::VALUE_W-1:0] value,
    output logic                        match
);
    import cvl_pkg::*;

    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic               match_reg;
    logic               match_next;
    logic               in_use;

    always_comb
    begin
        in_use     = CNT_W'(idx) < cmd.count;
        match_next = in_use && (value_reg == cmd.value);
        value_next = value_reg;
        if (cmd.append_en && (CNT_W'(idx) == cmd.count))
        begin
            value_next = cmd.value;
        end
        else if (cmd.delete_en && (idx >= cmd.pos))
        begin
            // shift down from the neighbor above
            value_next = next_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

FILE: rtl/cvl_first_match.sv
// ----------------------------------------------------------------------------
// cvl_first_match
// Two-level priority encoder over the cell match flags: a registered first
// level per group of cells, then a small pick of the lowest hit group.
// ----------------------------------------------------------------------------
module cvl_first_match (
    input  logic                      clk,
    input  logic [cvl_pkg::DEPTH-1:0] match,
    output logic                      hit,
    output logic [cvl_pkg::IDX_W-1:0] index
);
    import cvl_pkg::*;

    logic [PAD_W-1:0]      padded;
    logic [NUM_GROUPS-1:0] grp_hit_reg;
    logic [NUM_GROUPS-1:0] grp_hit_next;
    logic [SUB_W-1:0]      grp_sub_reg  [NUM_GROUPS];
    logic [SUB_W-1:0]      grp_sub_next [NUM_GROUPS];
    logic [GIDX_W-1:0]     sel_grp;
    logic [SUB_W-1:0]      sel_sub;

    assign padded = PAD_W'(match);

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_hit_next[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
            grp_sub_next[g] = '0;
            // walk down so the lowest set flag wins
            for (int j = GROUP_SIZE - 1; j >= 0; j--)
            begin
                if (padded[g*GROUP_SIZE + j])
                begin
                    grp_sub_next[g] = SUB_W'(j);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        grp_hit_reg <= grp_hit_next;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_sub_reg[g] <= grp_sub_next[g];
        end
    end

    always_comb
    begin
        sel_grp = '0;
        sel_sub = '0;
        for (int g = NUM_GROUPS - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                sel_grp = GIDX_W'(g);
                sel_sub = grp_sub_reg[g];
            end
        end
    end

    assign hit   = |grp_hit_reg;
    assign index = IDX_W'({sel_grp, sel_sub});

endmodule

FILE: rtl/compacting_value_list.sv
// ----------------------------------------------------------------------------
// compacting_value_list
// Bounded list of unsigned values in insertion order with append, search and
// delete-first-match; deletes close the gap by shifting later entries down.
// ----------------------------------------------------------------------------
// The list lives in a row of 64 cells; every cell compares its value with the
// item's value in parallel and a two-level first-match encoder picks the
// lowest hit. An item goes through compare, group encode, then resolve and
// update in the same cycle, which writes its result into the output register,
// and the next item is accepted in the cycle after that, so the block holds
// one item at a time. A result waiting in the output register does not block
// the next item until that item's resolve step. The capacity register may be
// written at any time the block is idle; values above 64 act as 64.
module compacting_value_list (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [cvl_pkg::CAP_W-1:0]       cfg_wdata,    // capacity
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cvl_pkg::IN_TDATA_W-1:0]  s_tdata,      // opcode, value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, found_index, entry_count, is_full, is_empty
    output logic [cvl_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import cvl_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic [CAP_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [OPCODE_W-1:0] op_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    result_t             m_data_reg;
    result_t             res;

    logic                res_fire;
    logic                append_ok;
    logic                delete_ok;
    logic [CNT_W-1:0]    eff_cap;
    cmd_t                cmd;
    logic [DEPTH-1:0]    match;
    logic [VALUE_W-1:0]  cell_value [DEPTH];
    logic                hit;
    logic [IDX_W-1:0]    hit_index;

    // ---------------- cell row
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_W-1:0] upper;
        if (i == DEPTH - 1)
        begin : g_top
            assign upper = cell_value[i];
        end
        else
        begin : g_mid
            assign upper = cell_value[i+1];
        end

        cvl_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .next_value (upper),
            .value      (cell_value[i]),
            .match      (match[i])
        );
    end

    cvl_first_match u_first (
        .clk   (clk),
        .match (match),
        .hit   (hit),
        .index (hit_index)
    );

    // ---------------- controller
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:   state_next = S_GRP;
            S_GRP:   state_next = S_RES;
            S_RES:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        res_fire = 1'b0;
        case (state_reg)
            S_IDLE:  s_tready = 1'b1;
            S_RES:   res_fire = !m_valid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                res_fire = 1'b0;
            end
        endcase
    end

    // ---------------- resolve
    always_comb
    begin
        eff_cap = (cap_reg > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_reg);
    end

    always_comb
    begin
        append_ok       = 1'b0;
        delete_ok       = 1'b0;
        res.status      = STAT_DONE;
        res.found_index = '0;
        count_next      = count_reg;
        case (op_reg)
            OP_APPEND:
            begin
                if (count_reg >= eff_cap)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    append_ok  = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_SEARCH:
            begin
                if (hit)
                begin
                    res.found_index = FIDX_W'(hit_index);
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            OP_DELETE:
            begin
                if (count_reg == '0)
                begin
                    res.status = STAT_EMPTY;
                end
                else if (hit)
                begin
                    delete_ok       = 1'b1;
                    res.found_index = FIDX_W'(hit_index);
                    count_next      = count_reg - 1'b1;
                end
                else
                begin
                    res.status = STAT_NOT_FOUND;
                end
            end
            default:
            begin
                res.status = STAT_DONE;
            end
        endcase
        res.entry_count = ECNT_W'(count_next);
        res.is_full     = count_next >= eff_cap;
        res.is_empty    = count_next == '0;
    end

    always_comb
    begin
        cmd.append_en = res_fire && append_ok;
        cmd.delete_en = res_fire && delete_ok;
        cmd.pos       = hit_index;
        cmd.count     = count_reg;
        cmd.value     = value_reg;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (res_fire)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (res_fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg    <= s_tdata[OPCODE_W-1:0];
            value_reg <= s_tdata[OPCODE_W +: VALUE_W];
        end
        if (res_fire)
        begin
            m_data_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        res_fire && append_ok |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("accepted append did not grow the list");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && (m_data_reg.status == STAT_FULL) |-> m_data_reg.is_full)
        else $error("refused append without full flag");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("item accepted while one is in flight");
`endif

endmodule
